// ===== design/cpu_alu_with_flags_defines.svh =====
// ---------------------------------------------------------------------------
// cpu_alu_with_flags_defines.svh
// Assertion macros for the ALU block.
// ---------------------------------------------------------------------------
`ifndef CPU_ALU_WITH_FLAGS_DEFINES_SVH
`define CPU_ALU_WITH_FLAGS_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked only while out of reset.
`define CPUALU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cpu_alu_with_flags: assertion failed");

// Checked at every edge, reset included.
`define CPUALU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("cpu_alu_with_flags: assertion failed during reset");

`else

`define CPUALU_ASSERT(lbl, prop)
`define CPUALU_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== design/cpualu_pkg.sv =====
// ---------------------------------------------------------------------------
// cpualu_pkg
// Types and operation codes shared by the ALU modules.
// ---------------------------------------------------------------------------
package cpualu_pkg;

  localparam int unsigned ActionW = 5;
  localparam int unsigned WordW   = 16;
  localparam int unsigned ByteW   = 8;

  typedef enum logic [ActionW-1:0] {
    OP_ADD8  = 5'd0,
    OP_ADD16 = 5'd1,
    OP_AND   = 5'd2,
    OP_CPL   = 5'd3,
    OP_DEC8  = 5'd4,
    OP_DEC16 = 5'd5,
    OP_INC8  = 5'd6,
    OP_INC16 = 5'd7,
    OP_MUL   = 5'd8,
    OP_OR    = 5'd9,
    OP_RL    = 5'd10,
    OP_RLC   = 5'd11,
    OP_RRC   = 5'd12,
    OP_SEXT  = 5'd13,
    OP_SLL   = 5'd14,
    OP_SRA   = 5'd15,
    OP_SRL   = 5'd16,
    OP_SUB8  = 5'd17,
    OP_SUB16 = 5'd18,
    OP_XOR   = 5'd19
  } op_e;

  typedef struct packed {
    logic n;
    logic v;
    logic c;
    logic z;
  } flags_t;

  typedef struct packed {
    flags_t             flags;
    logic [WordW-1:0]   operand_b;
    logic [WordW-1:0]   operand_a;
    logic [ActionW-1:0] action;
  } req_t;

  typedef struct packed {
    flags_t           flags;
    logic [WordW-1:0] result;
  } res_t;

  localparam int unsigned ReqW   = $bits(req_t);
  localparam int unsigned ResW   = $bits(res_t);
  localparam int unsigned SDataW = ((ReqW + 7) / 8) * 8;
  localparam int unsigned MDataW = ((ResW + 7) / 8) * 8;

endpackage

// ===== design/cpualu_in_reg.sv =====
// ---------------------------------------------------------------------------
// cpualu_in_reg
// Input register: holds one operation request for the ALU.
// ---------------------------------------------------------------------------
module cpualu_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  cpualu_pkg::req_t   data_i,
  output logic               valid_o,
  input  logic               down_ready_i,
  output cpualu_pkg::req_t   data_o
);

  logic             valid_q, valid_d;
  cpualu_pkg::req_t data_q;

  // Stage frees up when empty or when its content moves on this cycle.
  assign ready_o = !valid_q || down_ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/cpualu_core.sv =====
// ---------------------------------------------------------------------------
// cpualu_core
// Combinational ALU datapath: result and NZVC flag update.
// ---------------------------------------------------------------------------
module cpualu_core (
  input  cpualu_pkg::req_t req_i,
  output cpualu_pkg::res_t res_o
);

  logic [cpualu_pkg::ByteW-1:0]   a8, b8;
  logic [cpualu_pkg::WordW-1:0]   a16, b16;
  logic [cpualu_pkg::ByteW:0]     sum8, diff8;
  logic [cpualu_pkg::WordW:0]     sum16, diff16;
  logic [cpualu_pkg::WordW-1:0]   prod;
  logic [cpualu_pkg::WordW-1:0]   r;
  logic                           upd_z, upd_n;
  logic                           n_val, c_val, v_val;
  cpualu_pkg::flags_t             fin;

  assign fin = req_i.flags;
  assign a16 = req_i.operand_a;
  assign b16 = req_i.operand_b;
  assign a8  = a16[cpualu_pkg::ByteW-1:0];
  assign b8  = b16[cpualu_pkg::ByteW-1:0];

  assign sum8   = {1'b0, a8} + {1'b0, b8};
  assign diff8  = {1'b0, a8} - {1'b0, b8};
  assign sum16  = {1'b0, a16} + {1'b0, b16};
  assign diff16 = {1'b0, a16} - {1'b0, b16};
  assign prod   = a8 * b8;

  always_comb begin
    r     = '0;
    upd_z = 1'b0;
    upd_n = 1'b0;
    n_val = fin.n;
    c_val = fin.c;
    v_val = fin.v;
    case (cpualu_pkg::op_e'(req_i.action))
      cpualu_pkg::OP_ADD8: begin
        r     = {8'h00, sum8[7:0]};
        upd_z = 1'b1;
        upd_n = 1'b1;
        c_val = sum8[8];
        v_val = ~(a8[7] ^ b8[7]) & (a8[7] ^ sum8[7]);
      end
      cpualu_pkg::OP_ADD16: begin
        r     = sum16[15:0];
        upd_z = 1'b1;
        upd_n = 1'b1;
        c_val = sum16[16];
        v_val = ~(a16[15] ^ b16[15]) & (a16[15] ^ sum16[15]);
      end
      cpualu_pkg::OP_SUB8: begin
        r     = {8'h00, diff8[7:0]};
        upd_z = 1'b1;
        upd_n = 1'b1;
        c_val = diff8[8];
        v_val = (a8[7] ^ b8[7]) & (a8[7] ^ diff8[7]);
      end
      cpualu_pkg::OP_SUB16: begin
        r     = diff16[15:0];
        upd_z = 1'b1;
        upd_n = 1'b1;
        c_val = diff16[16];
        v_val = (a16[15] ^ b16[15]) & (a16[15] ^ diff16[15]);
      end
      cpualu_pkg::OP_AND: begin
        r     = {8'h00, a8 & b8};
        upd_z = 1'b1;
        upd_n = 1'b1;
      end
      cpualu_pkg::OP_OR: begin
        r     = {8'h00, a8 | b8};
        upd_z = 1'b1;
        upd_n = 1'b1;
      end
      cpualu_pkg::OP_XOR: begin
        r     = {8'h00, a8 ^ b8};
        upd_z = 1'b1;
        upd_n = 1'b1;
      end
      cpualu_pkg::OP_CPL: begin
        r     = {8'h00, ~a8};
        upd_z = 1'b1;
        upd_n = 1'b1;
      end
      cpualu_pkg::OP_DEC8: begin
        r     = {8'h00, a8 - 8'd1};
        upd_z = 1'b1;
      end
      cpualu_pkg::OP_DEC16: begin
        r     = a16 - 16'd1;
        upd_z = 1'b1;
      end
      cpualu_pkg::OP_INC8: begin
        r     = {8'h00, a8 + 8'd1};
        upd_z = 1'b1;
      end
      cpualu_pkg::OP_INC16: begin
        r     = a16 + 16'd1;
        upd_z = 1'b1;
      end
      cpualu_pkg::OP_MUL: begin
        // N follows bit 7 of the product, not bit 15
        r     = prod;
        upd_z = 1'b1;
        upd_n = 1'b1;
        c_val = 1'b0;
        v_val = 1'b0;
      end
      cpualu_pkg::OP_RL: begin
        r     = {8'h00, a8[6:0], fin.c};
        upd_z = 1'b1;
        upd_n = 1'b1;
        c_val = a8[7];
      end
      cpualu_pkg::OP_RLC: begin
        r     = {8'h00, a8[6:0], a8[7]};
        upd_z = 1'b1;
        upd_n = 1'b1;
        c_val = a8[7];
      end
      cpualu_pkg::OP_RRC: begin
        r     = {8'h00, a8[0], a8[7:1]};
        upd_z = 1'b1;
        upd_n = 1'b1;
        c_val = a8[0];
      end
      cpualu_pkg::OP_SLL: begin
        r     = {8'h00, a8[6:0], 1'b0};
        upd_z = 1'b1;
        upd_n = 1'b1;
        c_val = a8[7];
      end
      cpualu_pkg::OP_SRA: begin
        r     = {8'h00, a8[7], a8[7:1]};
        upd_z = 1'b1;
        upd_n = 1'b1;
        c_val = a8[0];
        v_val = 1'b0;
      end
      cpualu_pkg::OP_SRL: begin
        r     = {8'h00, 1'b0, a8[7:1]};
        upd_z = 1'b1;
        upd_n = 1'b1;
        c_val = a8[0];
      end
      cpualu_pkg::OP_SEXT: begin
        r = {{8{a8[7]}}, a8};
      end
      default: begin
        r = '0;
      end
    endcase
  end

  // Byte results are zero-extended, so bit 7 serves as N for every op that updates
  // N but the 16-bit add/sub, which use bit 15; other ops keep the incoming N.
  always_comb begin
    res_o.result  = r;
    res_o.flags.z = upd_z ? (r == '0) : fin.z;
    res_o.flags.c = c_val;
    res_o.flags.v = v_val;
    if (cpualu_pkg::op_e'(req_i.action) == cpualu_pkg::OP_ADD16 ||
        cpualu_pkg::op_e'(req_i.action) == cpualu_pkg::OP_SUB16) begin
      res_o.flags.n = r[15];
    end else begin
      res_o.flags.n = upd_n ? r[7] : n_val;
    end
  end

endmodule

// ===== design/cpualu_out_reg.sv =====
// ---------------------------------------------------------------------------
// cpualu_out_reg
// Result register driving the output stream.
// ---------------------------------------------------------------------------
module cpualu_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  cpualu_pkg::res_t   data_i,
  output logic               valid_o,
  input  logic               down_ready_i,
  output cpualu_pkg::res_t   data_o
);

  logic             valid_q, valid_d;
  cpualu_pkg::res_t data_q;

  assign ready_o = !valid_q || down_ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/cpu_alu_with_flags.sv =====
// ---------------------------------------------------------------------------
// cpu_alu_with_flags
// 8-bit processor ALU with NZVC flags, one operation per transfer.
// ---------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   action, operand_a, operand_b, zero/carry/overflow/negative in
// m_axis    out  result, zero/carry/overflow/negative out
//
// Two register stages (input register, result register) with the ALU
// between them: one transfer per cycle sustained while m_axis is not stalled.
// Reset empties both stages; no result is pending after reset.
// A stall on m_axis holds the result register and backs up into the input
// register; s_axis_tready drops only when both stages are full.
// ---------------------------------------------------------------------------
`include "cpu_alu_with_flags_defines.svh"

module cpu_alu_with_flags (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [4:0] action, [20:5] operand_a, [36:21] operand_b, [37] zero_in,
  // [38] carry_in, [39] overflow_in, [40] negative_in, [47:41] zero
  input  logic [cpualu_pkg::SDataW-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [15:0] result, [16] zero_out, [17] carry_out, [18] overflow_out,
  // [19] negative_out, [23:20] zero
  output logic [cpualu_pkg::MDataW-1:0]   m_axis_tdata
);

  cpualu_pkg::req_t in_req, s1_req;
  cpualu_pkg::res_t core_res, out_res;
  logic             s1_valid, s2_ready;

  assign in_req = s_axis_tdata[cpualu_pkg::ReqW-1:0];

  cpualu_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .data_i       (in_req),
    .valid_o      (s1_valid),
    .down_ready_i (s2_ready),
    .data_o       (s1_req)
  );

  cpualu_core u_core (
    .req_i (s1_req),
    .res_o (core_res)
  );

  cpualu_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s1_valid),
    .ready_o      (s2_ready),
    .data_i       (core_res),
    .valid_o      (m_axis_tvalid),
    .down_ready_i (m_axis_tready),
    .data_o       (out_res)
  );

  assign m_axis_tdata = {{(cpualu_pkg::MDataW - cpualu_pkg::ResW){1'b0}}, out_res};

  `CPUALU_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_ni |=> !m_axis_tvalid)
  `CPUALU_ASSERT(a_advance_gives_result, (s1_valid && s2_ready) |=> m_axis_tvalid)
  `CPUALU_ASSERT(a_result_from_core,
                 (s1_valid && s2_ready) |=> (out_res == $past(core_res)))
  `CPUALU_ASSERT(a_result_has_source, $rose(m_axis_tvalid) |-> $past(s1_valid))

endmodule
